/* rtl/core/adpu_pkg.sv */
// ----------------------------------------------------------------------------
// adpu_pkg
// Shared types, codes and reset constants for the data-processing unit.
// ----------------------------------------------------------------------------
package adpu_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned RegIdxW = 4;
  localparam int unsigned NumRegs = 16;

  localparam logic [DataW-1:0] RESET_SP = 32'h0300_7F00;
  localparam logic [DataW-1:0] RESET_PC = 32'h0800_0000;

  localparam logic [RegIdxW-1:0] REG_SP = 4'd13;
  localparam logic [RegIdxW-1:0] REG_LR = 4'd14;
  localparam logic [RegIdxW-1:0] REG_PC = 4'd15;

  typedef enum logic [3:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_CS = 4'd2,
    COND_CC = 4'd3,
    COND_MI = 4'd4,
    COND_PL = 4'd5,
    COND_VS = 4'd6,
    COND_VC = 4'd7,
    COND_HI = 4'd8,
    COND_LS = 4'd9,
    COND_GE = 4'd10,
    COND_LT = 4'd11,
    COND_GT = 4'd12,
    COND_LE = 4'd13,
    COND_AL = 4'd14,
    COND_NV = 4'd15
  } cond_e;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_ADC = 4'd5,
    OP_SBC = 4'd6,
    OP_RSC = 4'd7,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } alu_op_e;

  typedef enum logic [1:0] {
    SHIFT_LSL = 2'd0,
    SHIFT_LSR = 2'd1,
    SHIFT_ASR = 2'd2,
    SHIFT_ROR = 2'd3
  } shift_kind_e;

  typedef struct packed {
    logic [3:0]         cond;
    logic [3:0]         alu_op;
    logic               set_flags;
    logic [RegIdxW-1:0] dest_reg;
    logic [RegIdxW-1:0] first_reg;
    logic [RegIdxW-1:0] second_reg;
    logic [1:0]         shift_kind;
    logic [4:0]         shift_count;
    logic               use_immediate;
    logic [DataW-1:0]   immediate_operand;
    logic               immediate_carry;
  } in_beat_t;

  typedef struct packed {
    logic             executed;
    logic [DataW-1:0] result_value;
    logic [3:0]       flags_out;
    logic             wrote_register;
  } out_beat_t;

  function automatic logic [DataW-1:0] reg_reset_val(input logic [RegIdxW-1:0] idx);
    logic [DataW-1:0] val;
    val = '0;
    case (idx) inside
      REG_SP:         val = RESET_SP;
      REG_LR, REG_PC: val = RESET_PC;
      default:        val = '0;
    endcase
    return val;
  endfunction

endpackage

/* rtl/core/adpu_regfile.sv */
// ----------------------------------------------------------------------------
// adpu_regfile
// 16 x 32 register memory, two synchronous read ports and one write port,
// with write-to-read bypass and per-entry valid bits for reset values.
// ----------------------------------------------------------------------------
module adpu_regfile (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [adpu_pkg::RegIdxW-1:0]      rd_addr_a_i,
  input  logic [adpu_pkg::RegIdxW-1:0]      rd_addr_b_i,
  output logic [adpu_pkg::DataW-1:0]        rd_data_a_o,
  output logic [adpu_pkg::DataW-1:0]        rd_data_b_o,
  input  logic                              wr_en_i,
  input  logic [adpu_pkg::RegIdxW-1:0]      wr_addr_i,
  input  logic [adpu_pkg::DataW-1:0]        wr_data_i
);

  logic [adpu_pkg::DataW-1:0]   mem [adpu_pkg::NumRegs];
  logic [adpu_pkg::NumRegs-1:0] vld_q;

  logic [adpu_pkg::DataW-1:0]   data_a_q, data_b_q;
  logic [adpu_pkg::RegIdxW-1:0] addr_a_q, addr_b_q;
  logic                         hit_a_q, hit_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // read-before-write array, bypass the write landing at the same edge
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      addr_a_q <= rd_addr_a_i;
      addr_b_q <= rd_addr_b_i;
      if (wr_en_i && (wr_addr_i == rd_addr_a_i)) begin
        data_a_q <= wr_data_i;
        hit_a_q  <= 1'b1;
      end else begin
        data_a_q <= mem[rd_addr_a_i];
        hit_a_q  <= vld_q[rd_addr_a_i];
      end
      if (wr_en_i && (wr_addr_i == rd_addr_b_i)) begin
        data_b_q <= wr_data_i;
        hit_b_q  <= 1'b1;
      end else begin
        data_b_q <= mem[rd_addr_b_i];
        hit_b_q  <= vld_q[rd_addr_b_i];
      end
    end
  end

  assign rd_data_a_o = hit_a_q ? data_a_q : adpu_pkg::reg_reset_val(addr_a_q);
  assign rd_data_b_o = hit_b_q ? data_b_q : adpu_pkg::reg_reset_val(addr_b_q);

endmodule

/* rtl/core/adpu_exec.sv */
// ----------------------------------------------------------------------------
// adpu_exec
// Condition check, immediate barrel shifter and ALU with NZCV generation.
// ----------------------------------------------------------------------------
module adpu_exec (
  input  adpu_pkg::in_beat_t          beat_i,
  input  logic [adpu_pkg::DataW-1:0]  rn_data_i,
  input  logic [adpu_pkg::DataW-1:0]  rm_data_i,
  input  logic [3:0]                  flags_i,
  output adpu_pkg::out_beat_t         beat_o,
  output logic                        wr_en_o
);

  logic        f_n, f_z, f_c, f_v;
  logic        pass;
  logic [31:0] sh_val;
  logic        sh_c;
  logic [32:0] lsl_w, lsr_w, asr_w;
  logic [63:0] ror_w;
  logic [31:0] op_b, add_x, add_y;
  logic        add_cin;
  logic [32:0] sum;
  logic [31:0] res;
  logic        c_new, v_new;
  logic        arith, test;
  logic [3:0]  flags_nxt;

  assign {f_n, f_z, f_c, f_v} = flags_i;

  always_comb begin
    pass = 1'b1;
    unique case (adpu_pkg::cond_e'(beat_i.cond))
      adpu_pkg::COND_EQ: pass = f_z;
      adpu_pkg::COND_NE: pass = !f_z;
      adpu_pkg::COND_CS: pass = f_c;
      adpu_pkg::COND_CC: pass = !f_c;
      adpu_pkg::COND_MI: pass = f_n;
      adpu_pkg::COND_PL: pass = !f_n;
      adpu_pkg::COND_VS: pass = f_v;
      adpu_pkg::COND_VC: pass = !f_v;
      adpu_pkg::COND_HI: pass = f_c && !f_z;
      adpu_pkg::COND_LS: pass = !f_c || f_z;
      adpu_pkg::COND_GE: pass = (f_n == f_v);
      adpu_pkg::COND_LT: pass = (f_n != f_v);
      adpu_pkg::COND_GT: pass = !f_z && (f_n == f_v);
      adpu_pkg::COND_LE: pass = f_z || (f_n != f_v);
      default:           pass = 1'b1;
    endcase
  end

  // shifter
  assign lsl_w = {1'b0, rm_data_i} << beat_i.shift_count;
  assign lsr_w = {rm_data_i, 1'b0} >> beat_i.shift_count;
  assign asr_w = 33'($signed({rm_data_i, 1'b0}) >>> beat_i.shift_count);
  assign ror_w = {rm_data_i, rm_data_i} >> beat_i.shift_count;

  always_comb begin
    sh_val = rm_data_i;
    sh_c   = f_c;
    case (adpu_pkg::shift_kind_e'(beat_i.shift_kind))
      adpu_pkg::SHIFT_LSL: begin
        if (beat_i.shift_count != '0) begin
          sh_val = lsl_w[31:0];
          sh_c   = lsl_w[32];
        end
      end
      adpu_pkg::SHIFT_LSR: begin
        if (beat_i.shift_count == '0) begin
          sh_val = '0;
          sh_c   = rm_data_i[31];
        end else begin
          sh_val = lsr_w[32:1];
          sh_c   = lsr_w[0];
        end
      end
      adpu_pkg::SHIFT_ASR: begin
        if (beat_i.shift_count == '0) begin
          sh_val = {32{rm_data_i[31]}};
          sh_c   = rm_data_i[31];
        end else begin
          sh_val = asr_w[32:1];
          sh_c   = asr_w[0];
        end
      end
      default: begin
        if (beat_i.shift_count == '0) begin
          sh_val = {f_c, rm_data_i[31:1]};
          sh_c   = rm_data_i[0];
        end else begin
          sh_val = ror_w[31:0];
          sh_c   = ror_w[31];
        end
      end
    endcase
    if (beat_i.use_immediate) begin
      sh_val = beat_i.immediate_operand;
      sh_c   = beat_i.immediate_carry;
    end
  end

  assign op_b = sh_val;

  // shared adder operand select
  always_comb begin
    add_x   = rn_data_i;
    add_y   = op_b;
    add_cin = 1'b0;
    arith   = 1'b1;
    case (adpu_pkg::alu_op_e'(beat_i.alu_op))
      adpu_pkg::OP_SUB, adpu_pkg::OP_CMP: begin
        add_y   = ~op_b;
        add_cin = 1'b1;
      end
      adpu_pkg::OP_RSB: begin
        add_x   = op_b;
        add_y   = ~rn_data_i;
        add_cin = 1'b1;
      end
      adpu_pkg::OP_ADD, adpu_pkg::OP_CMN: add_cin = 1'b0;
      adpu_pkg::OP_ADC: add_cin = f_c;
      adpu_pkg::OP_SBC: begin
        add_y   = ~op_b;
        add_cin = f_c;
      end
      adpu_pkg::OP_RSC: begin
        add_x   = op_b;
        add_y   = ~rn_data_i;
        add_cin = f_c;
      end
      default: arith = 1'b0;
    endcase
  end

  assign sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};

  always_comb begin
    case (adpu_pkg::alu_op_e'(beat_i.alu_op))
      adpu_pkg::OP_AND, adpu_pkg::OP_TST: res = rn_data_i & op_b;
      adpu_pkg::OP_EOR, adpu_pkg::OP_TEQ: res = rn_data_i ^ op_b;
      adpu_pkg::OP_ORR:                   res = rn_data_i | op_b;
      adpu_pkg::OP_MOV:                   res = op_b;
      adpu_pkg::OP_BIC:                   res = rn_data_i & ~op_b;
      adpu_pkg::OP_MVN:                   res = ~op_b;
      default:                            res = sum[31:0];
    endcase
  end

  always_comb begin
    if (arith) begin
      c_new = sum[32];
      v_new = ((add_x[31] ^ sum[31]) & (add_y[31] ^ sum[31]));
    end else begin
      c_new = sh_c;
      v_new = f_v;
    end
  end

  assign test = (beat_i.alu_op == adpu_pkg::OP_TST) || (beat_i.alu_op == adpu_pkg::OP_TEQ) ||
                (beat_i.alu_op == adpu_pkg::OP_CMP) || (beat_i.alu_op == adpu_pkg::OP_CMN);

  assign flags_nxt = (test || beat_i.set_flags) ? {res[31], (res == '0), c_new, v_new} : flags_i;

  always_comb begin
    beat_o = '0;
    if (pass) begin
      beat_o.executed       = 1'b1;
      beat_o.result_value   = res;
      beat_o.flags_out      = flags_nxt;
      beat_o.wrote_register = !test;
    end else begin
      beat_o.flags_out      = flags_i;
    end
  end

  assign wr_en_o = pass && !test;

endmodule

/* rtl/core/arm_data_processing_unit_top.sv */
// ----------------------------------------------------------------------------
// arm_data_processing_unit_top
// ARMv4 data-processing execute unit: condition check, immediate barrel
// shifter, 16-operation ALU, register file and NZCV flags.
// ----------------------------------------------------------------------------
// Takes one instruction beat per clock while the output is not stalled and
// returns one result beat for each, through the execute stage register and
// the output register. The register file is a 16-entry memory read at Rn and
// Rm in the accept cycle, with the read data registered; the write of the
// instruction ahead lands at that same edge and is bypassed into the read, so
// dependent instructions issue back to back. Flags live in a register updated
// as each instruction retires. The output register and the execute stage
// together hold two beats while the output is stalled.
module arm_data_processing_unit_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  adpu_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output adpu_pkg::out_beat_t out_beat_o
);

  logic                       s1_valid_q;
  adpu_pkg::in_beat_t         s1_beat_q;
  logic                       out_valid_q;
  adpu_pkg::out_beat_t        out_beat_q;
  logic [3:0]                 flags_q;

  logic                       in_acc;
  logic                       s1_adv;
  logic [adpu_pkg::DataW-1:0] rn_data, rm_data;
  adpu_pkg::out_beat_t        ex_beat;
  logic                       ex_wr_en;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  adpu_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_acc),
    .rd_addr_a_i (in_beat_i.first_reg),
    .rd_addr_b_i (in_beat_i.second_reg),
    .rd_data_a_o (rn_data),
    .rd_data_b_o (rm_data),
    .wr_en_i     (s1_adv && ex_wr_en),
    .wr_addr_i   (s1_beat_q.dest_reg),
    .wr_data_i   (ex_beat.result_value)
  );

  adpu_exec u_exec (
    .beat_i    (s1_beat_q),
    .rn_data_i (rn_data),
    .rm_data_i (rm_data),
    .flags_i   (flags_q),
    .beat_o    (ex_beat),
    .wr_en_o   (ex_wr_en)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        flags_q     <= ex_beat.flags_out;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_beat_q <= in_beat_i;
    end
    if (s1_adv) begin
      out_beat_q <= ex_beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

/* dv/arm_data_processing_unit_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arm_data_processing_unit_top_tb
// Drives ARM data-processing instruction beats into the execute unit and
// checks every result beat against an in-order prediction of condition
// check, barrel shifter, ALU, register file and NZCV flags, with random
// idle cycles on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module arm_data_processing_unit_top_tb;

  class exec_scoreboard;
    logic [adpu_pkg::DataW-1:0] regs [adpu_pkg::NumRegs];
    logic [3:0]                 nzcv;
    adpu_pkg::out_beat_t        pending[$];
    int                         mismatches;
    int                         n_executed;
    int                         n_skipped;
    int                         n_tests;

    function new();
      for (int i = 0; i < adpu_pkg::NumRegs; i++) regs[i] = '0;
      regs[adpu_pkg::REG_SP] = adpu_pkg::RESET_SP;
      regs[adpu_pkg::REG_LR] = adpu_pkg::RESET_PC;
      regs[adpu_pkg::REG_PC] = adpu_pkg::RESET_PC;
      nzcv = '0;
      mismatches = 0;
      n_executed = 0;
      n_skipped = 0;
      n_tests = 0;
    endfunction

    function bit cond_holds(logic [3:0] c);
      logic n, z, cf, v;
      {n, z, cf, v} = nzcv;
      case (adpu_pkg::cond_e'(c))
        adpu_pkg::COND_EQ: return z;
        adpu_pkg::COND_NE: return !z;
        adpu_pkg::COND_CS: return cf;
        adpu_pkg::COND_CC: return !cf;
        adpu_pkg::COND_MI: return n;
        adpu_pkg::COND_PL: return !n;
        adpu_pkg::COND_VS: return v;
        adpu_pkg::COND_VC: return !v;
        adpu_pkg::COND_HI: return cf && !z;
        adpu_pkg::COND_LS: return !cf || z;
        adpu_pkg::COND_GE: return n == v;
        adpu_pkg::COND_LT: return n != v;
        adpu_pkg::COND_GT: return !z && (n == v);
        adpu_pkg::COND_LE: return z || (n != v);
        default: return 1'b1;
      endcase
    endfunction

    function logic [adpu_pkg::DataW-1:0] shift_rm(logic [adpu_pkg::DataW-1:0] val,
                                                  logic [1:0] kind, logic [4:0] cnt,
                                                  logic cin, output logic cout);
      logic signed [adpu_pkg::DataW-1:0] sval;
      sval = val;
      case (adpu_pkg::shift_kind_e'(kind))
        adpu_pkg::SHIFT_LSL: begin
          if (cnt == 0) begin
            cout = cin;
            return val;
          end
          cout = val[32 - cnt];
          return val << cnt;
        end
        adpu_pkg::SHIFT_LSR: begin
          if (cnt == 0) begin
            cout = val[31];
            return '0;
          end
          cout = val[cnt - 1];
          return val >> cnt;
        end
        adpu_pkg::SHIFT_ASR: begin
          if (cnt == 0) begin
            cout = val[31];
            return {adpu_pkg::DataW{val[31]}};
          end
          cout = val[cnt - 1];
          return sval >>> cnt;
        end
        default: begin
          // rrx when the count is zero
          if (cnt == 0) begin
            cout = val[0];
            return {cin, val[31:1]};
          end
          cout = val[cnt - 1];
          return (val >> cnt) | (val << (32 - cnt));
        end
      endcase
    endfunction

    function logic [adpu_pkg::DataW-1:0] add_carry(logic [adpu_pkg::DataW-1:0] a,
                                                   logic [adpu_pkg::DataW-1:0] b,
                                                   logic cin, output logic cout,
                                                   output logic ovf);
      logic [adpu_pkg::DataW:0] s;
      s = {1'b0, a} + {1'b0, b} + {{adpu_pkg::DataW{1'b0}}, cin};
      cout = s[adpu_pkg::DataW];
      ovf = (a[31] == b[31]) && (s[31] != a[31]);
      return s[adpu_pkg::DataW-1:0];
    endfunction

    function void note_input(adpu_pkg::in_beat_t b);
      adpu_pkg::out_beat_t        exp;
      logic [adpu_pkg::DataW-1:0] a, op2, r;
      logic                       sc, c, v, cf, logical, test;
      adpu_pkg::alu_op_e          op;
      exp = '0;
      cf = nzcv[1];
      op = adpu_pkg::alu_op_e'(b.alu_op);
      if (!cond_holds(b.cond)) begin
        n_skipped++;
        exp.flags_out = nzcv;
        pending.push_back(exp);
        return;
      end
      n_executed++;
      a = regs[b.first_reg];
      if (b.use_immediate) begin
        op2 = b.immediate_operand;
        sc = b.immediate_carry;
      end else begin
        op2 = shift_rm(regs[b.second_reg], b.shift_kind, b.shift_count, cf, sc);
      end
      c = cf;
      v = nzcv[0];
      logical = 1'b0;
      case (op)
        adpu_pkg::OP_AND, adpu_pkg::OP_TST: begin r = a & op2; logical = 1'b1; end
        adpu_pkg::OP_EOR, adpu_pkg::OP_TEQ: begin r = a ^ op2; logical = 1'b1; end
        adpu_pkg::OP_SUB, adpu_pkg::OP_CMP: r = add_carry(a, ~op2, 1'b1, c, v);
        adpu_pkg::OP_RSB:                   r = add_carry(op2, ~a, 1'b1, c, v);
        adpu_pkg::OP_ADD, adpu_pkg::OP_CMN: r = add_carry(a, op2, 1'b0, c, v);
        adpu_pkg::OP_ADC:                   r = add_carry(a, op2, cf, c, v);
        adpu_pkg::OP_SBC:                   r = add_carry(a, ~op2, cf, c, v);
        adpu_pkg::OP_RSC:                   r = add_carry(op2, ~a, cf, c, v);
        adpu_pkg::OP_ORR:                   begin r = a | op2; logical = 1'b1; end
        adpu_pkg::OP_MOV:                   begin r = op2; logical = 1'b1; end
        adpu_pkg::OP_BIC:                   begin r = a & ~op2; logical = 1'b1; end
        default:                            begin r = ~op2; logical = 1'b1; end
      endcase
      // logical ops take the shifter carry and keep v
      if (logical) begin
        c = sc;
        v = nzcv[0];
      end
      test = op inside {adpu_pkg::OP_TST, adpu_pkg::OP_TEQ, adpu_pkg::OP_CMP, adpu_pkg::OP_CMN};
      if (test) n_tests++;
      if (test || b.set_flags) nzcv = {r[31], r == '0, c, v};
      if (!test) regs[b.dest_reg] = r;
      exp.executed = 1'b1;
      exp.result_value = r;
      exp.flags_out = nzcv;
      exp.wrote_register = !test;
      pending.push_back(exp);
    endfunction

    function void compare_field(string what, logic [adpu_pkg::DataW-1:0] want,
                                logic [adpu_pkg::DataW-1:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
    endfunction

    function void check_result(adpu_pkg::out_beat_t got);
      adpu_pkg::out_beat_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        return;
      end
      exp = pending.pop_front();
      compare_field("executed", 32'(exp.executed), 32'(got.executed));
      compare_field("result_value", exp.result_value, got.result_value);
      compare_field("flags_out", 32'(exp.flags_out), 32'(got.flags_out));
      compare_field("wrote_register", 32'(exp.wrote_register), 32'(got.wrote_register));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  adpu_pkg::in_beat_t  in_beat_i;
  logic                out_valid_o;
  logic                out_stall_i;
  adpu_pkg::out_beat_t out_beat_o;

  logic           calm;
  int             n_sent;
  exec_scoreboard sb = new();

  arm_data_processing_unit_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= !calm && ($urandom_range(0, 99) < 18);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_beat_o);
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d result beats outstanding", sb.pending.size());
    $display("Mismatches found");
    $finish;
  end

  function automatic adpu_pkg::in_beat_t make_beat(adpu_pkg::cond_e cond, adpu_pkg::alu_op_e op,
                                                   int s, int rd, int rn, int rm,
                                                   adpu_pkg::shift_kind_e kind, int cnt,
                                                   int useimm,
                                                   logic [adpu_pkg::DataW-1:0] imm, int immc);
    adpu_pkg::in_beat_t b;
    b.cond = cond;
    b.alu_op = op;
    b.set_flags = 1'(s);
    b.dest_reg = 4'(rd);
    b.first_reg = 4'(rn);
    b.second_reg = 4'(rm);
    b.shift_kind = kind;
    b.shift_count = 5'(cnt);
    b.use_immediate = 1'(useimm);
    b.immediate_operand = imm;
    b.immediate_carry = 1'(immc);
    return b;
  endfunction

  function automatic logic [adpu_pkg::DataW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'h0000_0001;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic adpu_pkg::in_beat_t random_beat();
    adpu_pkg::in_beat_t b;
    int                 roll;
    b.cond = 4'(($urandom_range(0, 99) < 55) ? $urandom_range(14, 15) : $urandom_range(0, 15));
    b.alu_op = 4'($urandom_range(0, 15));
    b.set_flags = 1'($urandom_range(0, 1));
    b.dest_reg = 4'($urandom_range(0, 15));
    b.first_reg = 4'($urandom_range(0, 15));
    b.second_reg = 4'($urandom_range(0, 15));
    b.shift_kind = 2'($urandom_range(0, 3));
    roll = $urandom_range(0, 99);
    b.shift_count = (roll < 25) ? 5'd0 : (roll < 35) ? 5'd31 : 5'($urandom_range(0, 31));
    b.use_immediate = 1'($urandom_range(0, 1));
    b.immediate_operand = pick_operand();
    b.immediate_carry = 1'($urandom_range(0, 1));
    // seed the register file with interesting values now and then
    if ($urandom_range(0, 99) < 20) begin
      b.alu_op = ($urandom_range(0, 1) != 0) ? adpu_pkg::OP_MOV : adpu_pkg::OP_MVN;
      b.use_immediate = 1'b1;
    end
    return b;
  endfunction

  task automatic send_beat(input adpu_pkg::in_beat_t b);
    while (!calm && $urandom_range(0, 99) < 18) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(b);
    n_sent++;
    @(negedge clk_i);
  endtask

  initial begin
    adpu_pkg::in_beat_t directed[$];
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_beat_i = '0;
    calm = 1'b0;
    n_sent = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed = {
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_MOV,
                1, 1, 0, 0, adpu_pkg::SHIFT_LSL, 0, 1, 32'hFFFF_FFFF, 1),
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_MOV,
                1, 2, 0, 0, adpu_pkg::SHIFT_LSL, 0, 1, 32'h8000_0000, 0),
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_MVN,
                1, 3, 0, 0, adpu_pkg::SHIFT_LSL, 0, 1, 32'h8000_0000, 1),
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_ADD,
                1, 4, 3, 0, adpu_pkg::SHIFT_LSL, 0, 1, 32'h0000_0001, 0),
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_ADC,
                1, 5, 1, 1, adpu_pkg::SHIFT_LSL, 0, 0, 32'h0, 0),
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_SUB,
                1, 6, 2, 1, adpu_pkg::SHIFT_LSR, 0, 0, 32'h0, 0),
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_RSB,
                1, 7, 1, 2, adpu_pkg::SHIFT_ASR, 0, 0, 32'h0, 0),
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_SBC,
                1, 8, 0, 3, adpu_pkg::SHIFT_ROR, 0, 0, 32'h0, 0),
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_RSC,
                1, 9, 3, 1, adpu_pkg::SHIFT_LSL, 31, 0, 32'h0, 0),
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_AND,
                1, 10, 1, 2, adpu_pkg::SHIFT_ROR, 31, 0, 32'h0, 0),
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_EOR,
                1, 11, 1, 3, adpu_pkg::SHIFT_ASR, 31, 0, 32'h0, 0),
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_ORR,
                0, 12, 13, 1, adpu_pkg::SHIFT_LSR, 31, 0, 32'h0, 0),
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_BIC,
                1, 0, 1, 0, adpu_pkg::SHIFT_LSL, 0, 1, 32'h0F0F_0F0F, 1),
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_TST,
                0, 4, 1, 2, adpu_pkg::SHIFT_LSL, 0, 0, 32'h0, 0),
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_TEQ,
                0, 4, 1, 1, adpu_pkg::SHIFT_LSL, 0, 0, 32'h0, 0),
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_CMP,
                0, 4, 2, 3, adpu_pkg::SHIFT_LSL, 0, 0, 32'h0, 0),
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_CMN,
                1, 4, 1, 0, adpu_pkg::SHIFT_LSL, 0, 1, 32'h0000_0001, 0),
      make_beat(adpu_pkg::COND_EQ, adpu_pkg::OP_MOV,
                1, 5, 0, 13, adpu_pkg::SHIFT_LSL, 0, 0, 32'h0, 0),
      make_beat(adpu_pkg::COND_NE, adpu_pkg::OP_MOV,
                1, 5, 0, 14, adpu_pkg::SHIFT_LSL, 0, 0, 32'h0, 0),
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_MOV,
                1, 15, 0, 0, adpu_pkg::SHIFT_LSL, 0, 1, 32'h0, 0),
      make_beat(adpu_pkg::COND_AL, adpu_pkg::OP_ADD,
                1, 6, 15, 14, adpu_pkg::SHIFT_LSL, 0, 0, 32'h0, 0),
      make_beat(adpu_pkg::COND_NV, adpu_pkg::OP_MOV,
                0, 7, 0, 13, adpu_pkg::SHIFT_ROR, 0, 0, 32'h0, 0),
      make_beat(adpu_pkg::COND_HI, adpu_pkg::OP_MVN,
                1, 8, 0, 0, adpu_pkg::SHIFT_LSL, 0, 1, 32'h0, 1),
      make_beat(adpu_pkg::COND_GT, adpu_pkg::OP_SUB,
                1, 9, 0, 0, adpu_pkg::SHIFT_LSL, 0, 1, 32'hFFFF_FFFF, 0)
    };
    foreach (directed[i]) send_beat(directed[i]);

    for (int i = 0; i < 750; i++) begin
      calm = (i >= 250 && i < 400);
      send_beat(random_beat());
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d instruction beats: %0d executed (%0d compare/test), %0d skipped on condition",
             n_sent, sb.n_executed, sb.n_tests, sb.n_skipped);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
